FILE: hdl/fntcs_pkg.sv
// Shared types and constants for the fat tree nearest candidate selector.
package fntcs_pkg;

   localparam int ID_BITS     = 16;
   localparam int LEVEL_W     = 2;
   localparam int NUM_LEVELS  = 3;
   localparam int CFG_W       = 7;
   localparam int HALF_W      = CFG_W - 1;
   // Largest group size: 127 * 63 * 63 needs 19 bits.
   localparam int SIZE_W      = 19;
   localparam int HI_W        = SIZE_W + 1;
   localparam int STEP_W      = $clog2(ID_BITS);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int CSR_IDX_W   = 2;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_OWN_ID       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TREE_ARITY   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VMS_PER_HOST = 2'd2;

   localparam logic [LEVEL_W-1:0] LEVEL_NONE = 2'd3;

   localparam logic [CFG_W-1:0] ARITY_RESET = 7'd4;
   localparam logic [CFG_W-1:0] VMS_RESET   = 7'd1;

   typedef struct packed {
      logic [ID_BITS-1:0]                    self_id;
      logic [NUM_LEVELS-1:0][ID_BITS-1:0]    lo;
      logic [NUM_LEVELS-1:0][HI_W-1:0]       hi;
   } bounds_type;

   typedef struct packed {
      logic [ID_BITS-1:0] id;
      logic               last;
      logic [LEVEL_W-1:0] level;
      logic [ID_BITS-1:0] delta;
   } cand_type;

endpackage

FILE: hdl/fat_tree_nearest_candidate_select_core.sv
// Top level of the fat tree nearest candidate selector.
// Throughput: one candidate per cycle while bounds are ready and nothing stalls; the queue
// lets front and back stall independently. rsp_tvalid is registered, set when the queue
// pops a list's last candidate. Reset and every configuration write start a group bound
// precompute (size products, a 16 step remainder per level); req_tready stays low meanwhile.
// Reset clears the running best and loads own_id 0, tree_arity 4, vms_per_host 1.
module fat_tree_nearest_candidate_select_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [fntcs_pkg::REQ_DATA_W-1:0] req_tdata,  // [15:0] candidate_id
   input  logic                             req_tlast,  // last_candidate
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [fntcs_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [15:0] chosen_id, [17:16] chosen_level
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [fntcs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fntcs_pkg::ID_BITS-1:0]    csr_data
);
   import fntcs_pkg::*;

   bounds_type         bounds;
   logic               bounds_ready;
   logic               queue_full;
   logic               queue_not_empty;
   logic               push;
   logic               pop;
   cand_type           push_item;
   cand_type           head;
   logic [ID_BITS-1:0] rsp_id;
   logic [LEVEL_W-1:0] rsp_level;

   fntcs_bounds u_bounds (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .bounds_ready (bounds_ready),
      .bounds       (bounds)
   );

   fntcs_front u_front (
      .bounds_ready (bounds_ready),
      .bounds       (bounds),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_id       (req_tdata[ID_BITS-1:0]),
      .req_tlast    (req_tlast),
      .queue_full   (queue_full),
      .push         (push),
      .push_item    (push_item)
   );

   fntcs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head      (head)
   );

   fntcs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .not_empty  (queue_not_empty),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_id     (rsp_id),
      .rsp_level  (rsp_level)
   );

   assign rsp_tdata = {(RSP_DATA_W - ID_BITS - LEVEL_W)'(0), rsp_level, rsp_id};

endmodule

FILE: hdl/fntcs_bounds.sv
// Configuration registers and group bound precompute for each tree level.
module fntcs_bounds (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [fntcs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fntcs_pkg::ID_BITS-1:0]    csr_data,
   output logic                             bounds_ready,
   output fntcs_pkg::bounds_type            bounds
);
   import fntcs_pkg::*;

   localparam logic [2:0] ST_SIZE0 = 3'd0;
   localparam logic [2:0] ST_SIZE1 = 3'd1;
   localparam logic [2:0] ST_SIZE2 = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_BOUND = 3'd4;
   localparam logic [2:0] ST_READY = 3'd5;

   logic [2:0]                        state_ff, state_in;
   logic [ID_BITS-1:0]                own_ff, own_in;
   logic [CFG_W-1:0]                  arity_ff, arity_in;
   logic [CFG_W-1:0]                  vms_ff, vms_in;
   logic [HALF_W-1:0]                 half_ff, half_in;
   logic [NUM_LEVELS-1:0][SIZE_W-1:0] size_ff, size_in;
   logic [NUM_LEVELS-1:0][SIZE_W-1:0] rem_ff, rem_in;
   logic [ID_BITS-1:0]                div_ff, div_in;
   logic [STEP_W-1:0]                 step_ff, step_in;
   bounds_type                        bnd_ff, bnd_in;
   logic [SIZE_W-1:0]                 mul_src;
   logic [SIZE_W+HALF_W-1:0]          product;
   logic [SIZE_W:0]                   trial;
   logic                              csr_write;

   assign csr_ready    = 1'b1;
   assign csr_write    = csr_valid && csr_ready;
   assign bounds_ready = (state_ff == ST_READY);
   assign bounds       = bnd_ff;

   assign mul_src = (state_ff == ST_SIZE1) ? size_ff[0] : size_ff[1];
   assign product = mul_src * half_ff;

   always_comb begin
      state_in = state_ff;
      own_in   = own_ff;
      arity_in = arity_ff;
      vms_in   = vms_ff;
      half_in  = half_ff;
      size_in  = size_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      step_in  = step_ff;
      bnd_in   = bnd_ff;
      trial    = '0;
      case (state_ff)
         ST_SIZE0: begin
            size_in[0] = (vms_ff == '0) ? SIZE_W'(1) : SIZE_W'(vms_ff);
            half_in    = (arity_ff[CFG_W-1:1] == '0) ? HALF_W'(1) : arity_ff[CFG_W-1:1];
            state_in   = ST_SIZE1;
         end
         ST_SIZE1: begin
            size_in[1] = product[SIZE_W-1:0];
            state_in   = ST_SIZE2;
         end
         ST_SIZE2: begin
            size_in[2] = product[SIZE_W-1:0];
            rem_in     = '0;
            div_in     = own_ff;
            step_in    = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            // One restoring step per lane: remainder of own id by each group size.
            for (int j = 0; j < NUM_LEVELS; j++) begin
               trial = {rem_ff[j], div_ff[ID_BITS-1]};
               if (trial >= {1'b0, size_ff[j]}) begin
                  trial = trial - {1'b0, size_ff[j]};
               end
               rem_in[j] = trial[SIZE_W-1:0];
            end
            div_in  = {div_ff[ID_BITS-2:0], 1'b0};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(ID_BITS - 1)) begin
               state_in = ST_BOUND;
            end
         end
         ST_BOUND: begin
            bnd_in.self_id = own_ff;
            for (int j = 0; j < NUM_LEVELS; j++) begin
               bnd_in.lo[j] = own_ff - rem_ff[j][ID_BITS-1:0];
               bnd_in.hi[j] = HI_W'(bnd_in.lo[j]) + HI_W'(size_ff[j]) - HI_W'(1);
            end
            state_in = ST_READY;
         end
         ST_READY: begin
            state_in = ST_READY;
         end
         default: begin
            state_in = ST_SIZE0;
         end
      endcase
      // A write restarts the precompute with the new value.
      if (csr_write) begin
         case (csr_index)
            CSR_OWN_ID:       own_in   = csr_data;
            CSR_TREE_ARITY:   arity_in = csr_data[CFG_W-1:0];
            CSR_VMS_PER_HOST: vms_in   = csr_data[CFG_W-1:0];
            default: ;
         endcase
         state_in = ST_SIZE0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SIZE0;
         own_ff   <= '0;
         arity_ff <= ARITY_RESET;
         vms_ff   <= VMS_RESET;
      end else begin
         state_ff <= state_in;
         own_ff   <= own_in;
         arity_ff <= arity_in;
         vms_ff   <= vms_in;
      end
      half_ff <= half_in;
      size_ff <= size_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      step_ff <= step_in;
      bnd_ff  <= bnd_in;
   end

endmodule

FILE: hdl/fntcs_front.sv
// Front end: accepts candidates and classifies hop level and distance.
module fntcs_front (
   input  logic                             bounds_ready,
   input  fntcs_pkg::bounds_type            bounds,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [fntcs_pkg::ID_BITS-1:0]    req_id,
   input  logic                             req_tlast,
   input  logic                             queue_full,
   output logic                             push,
   output fntcs_pkg::cand_type              push_item
);
   import fntcs_pkg::*;

   logic [NUM_LEVELS-1:0] in_group;

   assign req_tready = bounds_ready && !queue_full;
   assign push       = req_tvalid && req_tready;

   always_comb begin
      for (int j = 0; j < NUM_LEVELS; j++) begin
         in_group[j] = (req_id >= bounds.lo[j]) && (HI_W'(req_id) <= bounds.hi[j]);
      end
      push_item.id   = req_id;
      push_item.last = req_tlast;
      if (in_group[0]) begin
         push_item.level = LEVEL_W'(0);
      end else if (in_group[1]) begin
         push_item.level = LEVEL_W'(1);
      end else if (in_group[2]) begin
         push_item.level = LEVEL_W'(2);
      end else begin
         push_item.level = LEVEL_NONE;
      end
      push_item.delta = (bounds.self_id >= req_id) ? (bounds.self_id - req_id)
                                                   : (req_id - bounds.self_id);
   end

endmodule

FILE: hdl/fntcs_queue.sv
// Short queue of classified candidates between front and back.
module fntcs_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  fntcs_pkg::cand_type  push_item,
   input  logic                 pop,
   output logic                 full,
   output logic                 not_empty,
   output fntcs_pkg::cand_type  head
);
   import fntcs_pkg::*;

   cand_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in;
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QPTR_W:0]     count_ff, count_in;

   assign full      = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ff];

   always_comb begin
      wr_in    = push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in    = pop ? rd_ff + QPTR_W'(1) : rd_ff;
      count_in = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (push) begin
         entry_ff[wr_ff] <= push_item;
      end
   end

endmodule

FILE: hdl/fntcs_back.sv
// Back end: running best selection and registered result.
module fntcs_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             not_empty,
   input  fntcs_pkg::cand_type              head,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [fntcs_pkg::ID_BITS-1:0]    rsp_id,
   output logic [fntcs_pkg::LEVEL_W-1:0]    rsp_level
);
   import fntcs_pkg::*;

   logic               have_ff, have_in;
   logic [LEVEL_W-1:0] lvl_ff, lvl_in;
   logic [ID_BITS-1:0] dist_ff, dist_in;
   logic [ID_BITS-1:0] node_ff, node_in;
   logic               out_valid_ff, out_valid_in;
   logic [ID_BITS-1:0] out_id_ff, out_id_in;
   logic [LEVEL_W-1:0] out_lvl_ff, out_lvl_in;
   logic               take;
   logic               out_free;
   logic [LEVEL_W-1:0] nb_lvl;
   logic [ID_BITS-1:0] nb_dist;
   logic [ID_BITS-1:0] nb_node;

   assign out_free   = !out_valid_ff || rsp_tready;
   // Hold a last item until the result register can take it.
   assign pop        = not_empty && (!head.last || out_free);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_id     = out_id_ff;
   assign rsp_level  = out_lvl_ff;

   always_comb begin
      if (!have_ff) begin
         take = 1'b1;
      end else if (head.level != lvl_ff) begin
         take = head.level < lvl_ff;
      end else if (head.delta != dist_ff) begin
         take = head.delta < dist_ff;
      end else begin
         take = head.id < node_ff;
      end
      nb_lvl  = take ? head.level : lvl_ff;
      nb_dist = take ? head.delta : dist_ff;
      nb_node = take ? head.id    : node_ff;

      have_in      = have_ff;
      lvl_in       = lvl_ff;
      dist_in      = dist_ff;
      node_in      = node_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_id_in    = out_id_ff;
      out_lvl_in   = out_lvl_ff;
      if (pop) begin
         if (head.last) begin
            out_valid_in = 1'b1;
            out_id_in    = nb_node;
            out_lvl_in   = nb_lvl;
            have_in      = 1'b0;
            lvl_in       = LEVEL_NONE;
            dist_in      = '1;
            node_in      = '0;
         end else begin
            have_in = 1'b1;
            lvl_in  = nb_lvl;
            dist_in = nb_dist;
            node_in = nb_node;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff      <= 1'b0;
         lvl_ff       <= LEVEL_NONE;
         dist_ff      <= '1;
         node_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         have_ff      <= have_in;
         lvl_ff       <= lvl_in;
         dist_ff      <= dist_in;
         node_ff      <= node_in;
         out_valid_ff <= out_valid_in;
      end
      out_id_ff  <= out_id_in;
      out_lvl_ff <= out_lvl_in;
   end

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (pop && head.last) |=> (!have_ff && lvl_ff == LEVEL_NONE))
      else $error("running best not cleared after last item");

   a_result_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(pop && head.last))
      else $error("result raised without a last item");

   a_no_pop_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready && not_empty && head.last) |-> !pop)
      else $error("last item popped while result register is full");

   a_empty_best_level: assert property (@(posedge clock) disable iff (reset)
      !have_ff |-> (lvl_ff == LEVEL_NONE))
      else $error("empty running best carries a level");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the fat tree nearest candidate selector core.
`timescale 1ns / 100ps

module testbench;
   import fntcs_pkg::*;

   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int PHASE_ITEMS     = 180;
   localparam int SETTLE_CYCLES   = 8;

   typedef struct packed {
      logic [ID_BITS-1:0] id;
      logic [LEVEL_W-1:0] level;
   } choice_type;

   typedef enum {RSP_ALWAYS, RSP_RANDOM, RSP_PATTERN} rsp_style_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [ID_BITS-1:0]    csr_data;

   // Mirror of the configuration registers.
   logic [ID_BITS-1:0] own_cfg   = '0;
   logic [CFG_W-1:0]   arity_cfg = ARITY_RESET;
   logic [CFG_W-1:0]   vms_cfg   = VMS_RESET;

   // Running best of the list in progress.
   logic [LEVEL_W-1:0] run_level = LEVEL_NONE;
   logic [ID_BITS:0]   run_dist  = '1;
   logic [ID_BITS-1:0] run_node  = '0;
   bit                 run_valid = 1'b0;

   choice_type    expected_choices[$];
   int            mismatch_count = 0;
   int            idle_cycles    = 0;
   int            burst_left     = 0;
   bit            gaps_enabled   = 1'b1;
   bit            hold_pending   = 1'b0;
   rsp_style_type rsp_mode       = RSP_ALWAYS;

   fat_tree_nearest_candidate_select_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Group size at level j under the current configuration.
   function automatic int unsigned level_size(input int j);
      int unsigned half;
      int unsigned size;
      half = arity_cfg / 2;
      if (half == 0) half = 1;
      size = vms_cfg;
      if (size == 0) size = 1;
      repeat (j) size = size * half;
      return size;
   endfunction

   function automatic logic [LEVEL_W-1:0] hop_level_of(input logic [ID_BITS-1:0] cand);
      int unsigned self_u;
      int unsigned cand_u;
      int unsigned size;
      self_u = own_cfg;
      cand_u = cand;
      for (int j = 0; j < NUM_LEVELS; j++) begin
         size = level_size(j);
         if (self_u / size == cand_u / size) return LEVEL_W'(j);
      end
      return LEVEL_NONE;
   endfunction

   // Fold one candidate into the running best; close the list on its last item.
   function automatic void track_candidate(input logic [ID_BITS-1:0] cand, input logic last);
      logic [LEVEL_W-1:0] lvl;
      logic [ID_BITS:0]   delta;
      bit                 take;
      choice_type         pick;
      lvl   = hop_level_of(cand);
      delta = (own_cfg >= cand) ? {1'b0, own_cfg - cand} : {1'b0, cand - own_cfg};
      if (!run_valid)              take = 1'b1;
      else if (lvl != run_level)   take = lvl < run_level;
      else if (delta != run_dist)  take = delta < run_dist;
      else                         take = cand < run_node;
      if (take) begin
         run_level = lvl;
         run_dist  = delta;
         run_node  = cand;
         run_valid = 1'b1;
      end
      if (last) begin
         pick.id    = run_node;
         pick.level = run_level;
         expected_choices = {expected_choices, pick};
         run_level = LEVEL_NONE;
         run_dist  = '1;
         run_node  = '0;
         run_valid = 1'b0;
      end
   endfunction

   // Follow every handshake: mirror register writes, predict, and check results.
   always @(posedge clock) begin : monitor
      choice_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_OWN_ID:       own_cfg   = csr_data;
               CSR_TREE_ARITY:   arity_cfg = csr_data[CFG_W-1:0];
               CSR_VMS_PER_HOST: vms_cfg   = csr_data[CFG_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            track_candidate(req_tdata[ID_BITS-1:0], req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_choices.size() == 0) begin
               mismatch_count++;
               $display("%0t: result with none pending: chosen_id %h chosen_level %0d",
                        $time, rsp_tdata[15:0], rsp_tdata[17:16]);
            end else begin
               want = expected_choices.pop_front();
               if (rsp_tdata[15:0] !== want.id) begin
                  mismatch_count++;
                  $display("%0t: chosen_id expected %h actual %h",
                           $time, want.id, rsp_tdata[15:0]);
               end
               if (rsp_tdata[17:16] !== want.level) begin
                  mismatch_count++;
                  $display("%0t: chosen_level expected %0d actual %0d",
                           $time, want.level, rsp_tdata[17:16]);
               end
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Result side: long hold on request, otherwise the current stall style.
   initial begin : rsp_side
      int unsigned beat;
      logic [7:0]  stall_pattern;
      beat          = 0;
      stall_pattern = 8'b1011_0110;
      rsp_tready    = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
            hold_pending = 1'b0;
         end
         beat++;
         case (rsp_mode)
            RSP_ALWAYS: rsp_tready <= 1'b1;
            RSP_RANDOM: rsp_tready <= ($urandom_range(0, 3) != 0);
            default:    rsp_tready <= stall_pattern[beat % 8];
         endcase
      end
   end

   // Offer one item; called and returns at a falling edge.
   task automatic send_candidate(input logic [ID_BITS-1:0] cand, input logic last);
      req_tvalid <= 1'b1;
      req_tdata  <= cand;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 15);
         if (gaps_enabled) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
   endtask

   // Stop offering and wait until every pending result has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_choices.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [ID_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(input logic [ID_BITS-1:0] own, input logic [CFG_W-1:0] arity,
                            input logic [CFG_W-1:0] vms);
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      write_csr(CSR_OWN_ID, own);
      write_csr(CSR_TREE_ARITY, {9'd0, arity});
      write_csr(CSR_VMS_PER_HOST, {9'd0, vms});
   endtask

   task automatic test_reset_defaults();
      send_candidate(16'h0000, 1'b1);
      send_candidate(16'hFFFF, 1'b1);
      send_candidate(16'h0003, 1'b0);
      send_candidate(16'h0001, 1'b0);
      send_candidate(16'h0002, 1'b1);
   endtask

   task automatic test_tie_breaks();
      configure(16'h8020, 7'd64, 7'd64);
      // equal distance on either side of own_id: smaller id wins
      send_candidate(16'h8030, 1'b0);
      send_candidate(16'h8010, 1'b1);
      send_candidate(16'h0000, 1'b0);
      send_candidate(16'hFFFF, 1'b1);
   endtask

   task automatic test_degenerate_groups();
      // arity below two and zero VMs per host collapse every level to size one
      configure(16'h0005, 7'd1, 7'd0);
      send_candidate(16'h0006, 1'b0);
      send_candidate(16'h0005, 1'b1);
      send_candidate(16'h0006, 1'b1);
      configure(16'h0005, 7'd0, 7'd1);
      send_candidate(16'h0004, 1'b0);
      send_candidate(16'h0007, 1'b1);
   endtask

   task automatic test_widest_groups();
      configure(16'hFFFF, 7'd127, 7'd127);
      send_candidate(16'h0000, 1'b1);
      send_candidate(16'h8000, 1'b0);
      send_candidate(16'h7FFF, 1'b1);
   endtask

   task automatic test_backpressure();
      gaps_enabled = 1'b0;
      rsp_mode     = RSP_ALWAYS;
      hold_pending = 1'b1;
      for (int i = 0; i < 40; i++) send_candidate(16'($urandom), 1'b1);
      drain_results();
      gaps_enabled = 1'b1;
   endtask

   task automatic test_random_lists(input int item_budget);
      int                 sent;
      int                 phase;
      int                 phase_sent;
      int                 len;
      int                 lvl;
      int unsigned        span;
      logic [ID_BITS-1:0] own;
      logic [CFG_W-1:0]   arity;
      logic [CFG_W-1:0]   vms;
      logic [ID_BITS-1:0] cand;
      logic [ID_BITS-1:0] prev;
      sent  = 0;
      phase = 0;
      prev  = '0;
      while (sent < item_budget) begin
         own = 16'($urandom);
         case ($urandom_range(0, 5))
            0: own = '0;
            1: own = '1;
            default: ;
         endcase
         case ($urandom_range(0, 7))
            0: arity = 7'd0;
            1: arity = 7'd1;
            2: arity = 7'd2;
            3: arity = 7'd127;
            default: arity = 7'($urandom_range(2, 64));
         endcase
         case ($urandom_range(0, 6))
            0: vms = 7'd0;
            1: vms = 7'd1;
            2: vms = 7'd127;
            3: vms = 7'd64;
            default: vms = 7'($urandom_range(1, 64));
         endcase
         configure(own, arity, vms);
         rsp_mode     = rsp_style_type'(phase % 3);
         gaps_enabled = (phase % 4) != 3;
         phase_sent   = 0;
         while (phase_sent < PHASE_ITEMS) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
               case ($urandom_range(0, 10))
                  0, 1, 2: cand = 16'($urandom);
                  3, 4, 5, 6: begin
                     // land within one group size of own_id, for a random level
                     lvl  = $urandom_range(0, 2);
                     span = level_size(lvl);
                     if (span > 65536) span = 65536;
                     cand = 16'(int'(own_cfg) + int'($urandom_range(0, 2 * span)) - int'(span));
                  end
                  7: cand = own_cfg;
                  8: cand = 16'(2 * own_cfg - prev);  // same distance as the previous one
                  9: cand = prev;
                  default: cand = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
               endcase
               prev = cand;
               send_candidate(cand, i == len - 1);
            end
            phase_sent += len;
         end
         sent += phase_sent;
         phase++;
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = CSR_OWN_ID;
      csr_data   = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_tie_breaks();
      test_degenerate_groups();
      test_widest_groups();
      test_backpressure();
      test_random_lists(1840);

      drain_results();
      repeat (10) @(negedge clock);
      if (mismatch_count == 0 && expected_choices.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
